### rtl/core/grp_pkg.sv
// grp_pkg: shared types and constants of the grid rectangle placer
// depends on nothing; imported by grid_rectangle_placer_core
`timescale 1ns / 1ps
`default_nettype none

package grp_pkg;

  localparam int CFG_W   = 12;
  localparam int COORD_W = 14;
  localparam int EXT_W   = 18;
  localparam int DIV_W   = 16;
  localparam int PIX_W   = 16;

  localparam logic [1:0] CFG_CELL_W   = 2'd0;
  localparam logic [1:0] CFG_CELL_H   = 2'd1;
  localparam logic [1:0] CFG_SCREEN_W = 2'd2;
  localparam logic [1:0] CFG_SCREEN_H = 2'd3;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] DIR_LEFT   = 2'd0;
  localparam logic [1:0] DIR_RIGHT  = 2'd1;
  localparam logic [1:0] DIR_TOP    = 2'd2;
  localparam logic [1:0] DIR_BOTTOM = 2'd3;

  localparam logic [2:0] PH_COLS = 3'd0;
  localparam logic [2:0] PH_ROWS = 3'd1;
  localparam logic [2:0] PH_NC   = 3'd2;
  localparam logic [2:0] PH_NR   = 3'd3;
  localparam logic [2:0] PH_C0   = 3'd4;
  localparam logic [2:0] PH_R0   = 3'd5;

  typedef enum logic [15:0] {
    ST_CLEAR   = 16'h0001,
    ST_IDLE    = 16'h0002,
    ST_SHIFT   = 16'h0004,
    ST_EXT     = 16'h0008,
    ST_DIV     = 16'h0010,
    ST_GEOM    = 16'h0020,
    ST_MAP     = 16'h0040,
    ST_CHK_RD  = 16'h0080,
    ST_CHK_DAT = 16'h0100,
    ST_NEXT    = 16'h0200,
    ST_CLAIM   = 16'h0400,
    ST_MULX    = 16'h0800,
    ST_MULY    = 16'h1000,
    ST_FIN     = 16'h2000,
    ST_DONE    = 16'h4000,
    ST_RM      = 16'h8000
  } state_e;

endpackage

`default_nettype wire

### rtl/core/grid_rectangle_placer_core.sv
// grid_rectangle_placer_core: occupancy grid allocator for screen rectangles
// one grid memory of used bit and owner tag per cell, sequencer, shared divider
// depends on grp_pkg
//
// usage: the slave stream carries one command beat, tuser selects add or remove.
// an add beat shifts the rectangle onto the screen, tries the run of cells at its
// corner, then scans start positions in the requested order; the first free run is
// claimed and the centred rectangle returns on the master stream, placed in tuser.
// a remove beat sweeps the grid and frees every cell of the owner, result all zero.
// an add runs six divisions on the shared divider, reads one grid cell at a time while
// checking runs and writes each claimed cell; a remove reads every cell of the grid once.
// one item is in work at a time; tready is high while the sequencer is idle.
// results sit in an output register, so the next beat is taken while a result
// waits; a stalled receiver holds the sequencer at its final step only.
// after reset a clearing pass writes every cell free; no beat is taken during it,
// config writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module grid_rectangle_placer_core
  import grp_pkg::*;
#(
  parameter int MAX_ROWS   = 32,
  parameter int MAX_COLS   = 64,
  parameter int OWNER_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // owner[15:0] left[29:16] top[43:30] right[57:44] bottom[71:58]
  // major_direction[73:72] minor_direction[75:74]
  input  wire logic [79:0] s_axis_tdata,
  // operation[0]
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_left[13:0] out_top[27:14] out_right[41:28] out_bottom[55:42]
  output logic [55:0]      m_axis_tdata,
  // placed[0]
  output logic [0:0]       m_axis_tuser
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MAXM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int IW    = $clog2(MAXM + 1);
  localparam int OW    = OWNER_BITS;

  state_e state_q, state_d;
  logic [AW:0] cnt_q, cnt_d;
  logic [2:0] phase_q, phase_d;
  logic [4:0] dcnt_q, dcnt_d;
  logic m_valid_q, m_valid_d;
  logic [CFG_W-1:0] cw_q, ch_q, sw_q, sh_q;

  logic op_q, op_d;
  logic [OW-1:0] tag_q, tag_d;
  logic signed [COORD_W-1:0] lft_q, tp_q, rgt_q, bot_q, lft_d, tp_d, rgt_d, bot_d;
  logic rows_up_q, cols_up_q, rows_outer_q, rows_up_d, cols_up_d, rows_outer_d;
  logic signed [EXT_W-1:0] x1_q, y1_q, x2_q, y2_q, w_q, h_q;
  logic signed [EXT_W-1:0] x1_d, y1_d, x2_d, y2_d, w_d, h_d;
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [CFG_W-1:0] rem_q, rem_d;
  logic [IW-1:0] cols_q, rows_q, cols_d, rows_d;
  logic [DIV_W-1:0] nc_q, nr_q, cq0_q, rq0_q, nc_d, nr_d, cq0_d, rq0_d;
  logic signed [EXT_W-1:0] mr_q, mc_q, mr_d, mc_d;
  logic corner_q, corner_d, found_q, found_d;
  logic [IW-1:0] i_q, j_q, r_q, c_q, ci_q, cj_q, i_d, j_d, r_d, c_d, ci_d, cj_d;
  logic [PIX_W-1:0] px_q, pw_q, py_q, ph_q, ox1_q, oy1_q;
  logic [PIX_W-1:0] px_d, pw_d, py_d, ph_d, ox1_d, oy1_d;
  logic rm_pend_q, rm_pend_d;
  logic [AW-1:0] rm_addr_q, rm_addr_d;
  logic [55:0] out_data_q, out_data_d;
  logic out_user_q, out_user_d;

  logic [OW:0] mem_q [DEPTH];
  logic [OW:0] rdata_q;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [OW:0] mem_wdata;

  logic [CFG_W-1:0] cw_eff, ch_eff, dvs;
  logic [DIV_W-1:0] div_in;
  logic [CFG_W:0] div_t, div_sub;
  logic div_ge;
  logic [IW-1:0] row_c, col_c;
  logic [AW-1:0] cell_addr;
  logic [31:0] owner_ext;
  logic signed [EXT_W-1:0] sw_s, sh_s, ax1, ax2, ay1, ay2, mr_c, mc_c;
  logic [27:0] mul_a, mul_b;
  logic last_col, last_row;
  logic out_free;

  assign cw_eff = (cw_q == '0) ? CFG_W'(1) : cw_q;
  assign ch_eff = (ch_q == '0) ? CFG_W'(1) : ch_q;
  assign owner_ext = 32'(s_axis_tdata[15:0]);
  assign sw_s = EXT_W'(signed'({1'b0, sw_q}));
  assign sh_s = EXT_W'(signed'({1'b0, sh_q}));
  assign mr_c = EXT_W'(signed'({1'b0, rows_q})) - EXT_W'(signed'({1'b0, nr_q}));
  assign mc_c = EXT_W'(signed'({1'b0, cols_q})) - EXT_W'(signed'({1'b0, nc_q}));

  assign row_c = r_q + ci_q;
  assign col_c = c_q + cj_q;
  assign cell_addr = AW'(row_c * MAX_COLS + col_c);
  assign last_col = (cj_q == nc_q[IW-1:0] - IW'(1));
  assign last_row = (ci_q == nr_q[IW-1:0] - IW'(1));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign out_free = !m_valid_q || m_axis_tready;

  // divider operands
  always_comb begin
    dvs = (phase_q == PH_COLS || phase_q == PH_NC || phase_q == PH_C0) ? cw_eff : ch_eff;
    case (phase_q)
      PH_COLS: div_in = DIV_W'(sw_q);
      PH_ROWS: div_in = DIV_W'(sh_q);
      PH_NC:   div_in = (w_q > 0) ? w_q[DIV_W-1:0] : '0;
      PH_NR:   div_in = (h_q > 0) ? h_q[DIV_W-1:0] : '0;
      PH_C0:   div_in = x1_q[EXT_W-1] ? '0 : x1_q[DIV_W-1:0];
      PH_R0:   div_in = y1_q[EXT_W-1] ? '0 : y1_q[DIV_W-1:0];
      default: div_in = '0;
    endcase
    div_t   = {rem_q, dvd_q[DIV_W-1]};
    div_ge  = (div_t >= {1'b0, dvs});
    div_sub = div_t - {1'b0, dvs};
  end

  // shift onto screen
  always_comb begin
    ax1 = EXT_W'(lft_q);
    ax2 = EXT_W'(rgt_q);
    ay1 = EXT_W'(tp_q);
    ay2 = EXT_W'(bot_q);
    if (ax1 < 0) begin
      ax2 = ax2 - ax1;
      ax1 = '0;
    end
    if (ay1 < 0) begin
      ay2 = ay2 - ay1;
      ay1 = '0;
    end
    if (ax2 >= sw_s) begin
      ax1 = ax1 - (ax2 - (sw_s - EXT_W'(1)));
      ax2 = sw_s - EXT_W'(1);
    end
    if (ay2 >= sh_s) begin
      ay1 = ay1 - (ay2 - (sh_s - EXT_W'(1)));
      ay2 = sh_s - EXT_W'(1);
    end
  end

  always_comb begin
    mul_a = 28'(c_q) * 28'(cw_eff);
    mul_b = 28'(nc_q) * 28'(cw_eff);
    if (state_q == ST_MULY) begin
      mul_a = 28'(r_q) * 28'(ch_eff);
      mul_b = 28'(nr_q) * 28'(ch_eff);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    phase_d = phase_q;
    dcnt_d = dcnt_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    op_d = op_q;
    tag_d = tag_q;
    lft_d = lft_q;
    tp_d = tp_q;
    rgt_d = rgt_q;
    bot_d = bot_q;
    rows_up_d = rows_up_q;
    cols_up_d = cols_up_q;
    rows_outer_d = rows_outer_q;
    x1_d = x1_q;
    y1_d = y1_q;
    x2_d = x2_q;
    y2_d = y2_q;
    w_d = w_q;
    h_d = h_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    cols_d = cols_q;
    rows_d = rows_q;
    nc_d = nc_q;
    nr_d = nr_q;
    cq0_d = cq0_q;
    rq0_d = rq0_q;
    mr_d = mr_q;
    mc_d = mc_q;
    corner_d = corner_q;
    found_d = found_q;
    i_d = i_q;
    j_d = j_q;
    r_d = r_q;
    c_d = c_q;
    ci_d = ci_q;
    cj_d = cj_q;
    px_d = px_q;
    pw_d = pw_q;
    py_d = py_q;
    ph_d = ph_q;
    ox1_d = ox1_q;
    oy1_d = oy1_q;
    rm_pend_d = 1'b0;
    rm_addr_d = rm_addr_q;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = cell_addr;
    mem_raddr = cell_addr;
    mem_wdata = {1'b1, tag_q};

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        mem_wdata = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d = s_axis_tuser[0];
          tag_d = owner_ext[OW-1:0];
          lft_d = s_axis_tdata[29:16];
          tp_d = s_axis_tdata[43:30];
          rgt_d = s_axis_tdata[57:44];
          bot_d = s_axis_tdata[71:58];
          rows_outer_d = !s_axis_tdata[73];
          if (!s_axis_tdata[73]) begin
            cols_up_d = (s_axis_tdata[73:72] == DIR_LEFT);
            rows_up_d = (s_axis_tdata[75:74] == DIR_TOP);
          end else begin
            rows_up_d = (s_axis_tdata[73:72] == DIR_TOP);
            cols_up_d = (s_axis_tdata[75:74] == DIR_LEFT);
          end
          found_d = 1'b0;
          cnt_d = '0;
          if (s_axis_tuser[0] == OP_REMOVE) begin
            state_d = ST_RM;
          end else begin
            state_d = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        x1_d = ax1;
        x2_d = ax2;
        y1_d = ay1;
        y2_d = ay2;
        state_d = ST_EXT;
      end
      ST_EXT: begin
        w_d = x2_q - x1_q;
        h_d = y2_q - y1_q;
        phase_d = PH_COLS;
        dcnt_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (dcnt_q == '0) begin
          dvd_d = div_in;
          rem_d = '0;
          dcnt_d = 5'd1;
        end else if (dcnt_q <= 5'(DIV_W)) begin
          rem_d = div_ge ? div_sub[CFG_W-1:0] : div_t[CFG_W-1:0];
          dvd_d = {dvd_q[DIV_W-2:0], div_ge};
          dcnt_d = dcnt_q + 1'b1;
        end else begin
          case (phase_q)
            PH_COLS: cols_d = (dvd_q > DIV_W'(MAX_COLS)) ? IW'(MAX_COLS) : IW'(dvd_q);
            PH_ROWS: rows_d = (dvd_q > DIV_W'(MAX_ROWS)) ? IW'(MAX_ROWS) : IW'(dvd_q);
            PH_NC: nc_d = (w_q > 0) ? dvd_q + DIV_W'(rem_q != '0) : DIV_W'(1);
            PH_NR: nr_d = (h_q > 0) ? dvd_q + DIV_W'(rem_q != '0) : DIV_W'(1);
            PH_C0: cq0_d = dvd_q;
            default: rq0_d = dvd_q;
          endcase
          dcnt_d = '0;
          if (phase_q == PH_R0) begin
            state_d = ST_GEOM;
          end else begin
            phase_d = phase_q + 1'b1;
          end
        end
      end
      ST_GEOM: begin
        mr_d = mr_c;
        mc_d = mc_c;
        i_d = '0;
        j_d = '0;
        ci_d = '0;
        cj_d = '0;
        if (!x1_q[EXT_W-1] && !y1_q[EXT_W-1] &&
            EXT_W'(signed'({1'b0, rq0_q})) <= mr_c &&
            EXT_W'(signed'({1'b0, cq0_q})) <= mc_c) begin
          corner_d = 1'b1;
          r_d = IW'(rq0_q);
          c_d = IW'(cq0_q);
          state_d = ST_CHK_RD;
        end else if (!mr_c[EXT_W-1] && !mc_c[EXT_W-1]) begin
          corner_d = 1'b0;
          state_d = ST_MAP;
        end else begin
          r_d = '0;
          c_d = '0;
          state_d = ST_MULX;
        end
      end
      ST_MAP: begin
        r_d = rows_up_q ? i_q : mr_q[IW-1:0] - i_q;
        c_d = cols_up_q ? j_q : mc_q[IW-1:0] - j_q;
        ci_d = '0;
        cj_d = '0;
        state_d = ST_CHK_RD;
      end
      ST_CHK_RD: begin
        mem_re = 1'b1;
        state_d = ST_CHK_DAT;
      end
      ST_CHK_DAT: begin
        if (rdata_q[OW]) begin
          state_d = ST_NEXT;
        end else if (last_col) begin
          cj_d = '0;
          if (last_row) begin
            ci_d = '0;
            state_d = ST_CLAIM;
          end else begin
            ci_d = ci_q + 1'b1;
            state_d = ST_CHK_RD;
          end
        end else begin
          cj_d = cj_q + 1'b1;
          state_d = ST_CHK_RD;
        end
      end
      ST_NEXT: begin
        state_d = ST_MAP;
        if (corner_q) begin
          corner_d = 1'b0;
          if (mr_q[EXT_W-1] || mc_q[EXT_W-1]) begin
            r_d = '0;
            c_d = '0;
            state_d = ST_MULX;
          end
        end else if (rows_outer_q) begin
          if (j_q == mc_q[IW-1:0]) begin
            j_d = '0;
            i_d = i_q + 1'b1;
            if (i_q == mr_q[IW-1:0]) begin
              r_d = '0;
              c_d = '0;
              state_d = ST_MULX;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          if (i_q == mr_q[IW-1:0]) begin
            i_d = '0;
            j_d = j_q + 1'b1;
            if (j_q == mc_q[IW-1:0]) begin
              r_d = '0;
              c_d = '0;
              state_d = ST_MULX;
            end
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      ST_CLAIM: begin
        mem_we = 1'b1;
        if (last_col) begin
          cj_d = '0;
          ci_d = ci_q + 1'b1;
          if (last_row) begin
            found_d = 1'b1;
            state_d = ST_MULX;
          end
        end else begin
          cj_d = cj_q + 1'b1;
        end
      end
      ST_MULX: begin
        px_d = mul_a[PIX_W-1:0];
        pw_d = mul_b[PIX_W-1:0];
        state_d = ST_MULY;
      end
      ST_MULY: begin
        py_d = mul_a[PIX_W-1:0];
        ph_d = mul_b[PIX_W-1:0];
        state_d = ST_FIN;
      end
      ST_FIN: begin
        ox1_d = px_q + ((pw_q - w_q[PIX_W-1:0]) >> 1);
        oy1_d = py_q + ((ph_q - h_q[PIX_W-1:0]) >> 1);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          if (op_q == OP_REMOVE) begin
            out_data_d = '0;
            out_user_d = 1'b0;
          end else begin
            out_data_d = {COORD_W'(oy1_q[COORD_W-1:0] + h_q[COORD_W-1:0]),
                          COORD_W'(ox1_q[COORD_W-1:0] + w_q[COORD_W-1:0]),
                          oy1_q[COORD_W-1:0], ox1_q[COORD_W-1:0]};
            out_user_d = found_q;
          end
          state_d = ST_IDLE;
        end
      end
      ST_RM: begin
        if (cnt_q < (AW+1)'(DEPTH)) begin
          mem_re = 1'b1;
          mem_raddr = cnt_q[AW-1:0];
          rm_pend_d = 1'b1;
          rm_addr_d = cnt_q[AW-1:0];
          cnt_d = cnt_q + 1'b1;
        end else if (!rm_pend_q) begin
          state_d = ST_DONE;
        end
        if (rm_pend_q && rdata_q[OW-1:0] == tag_q) begin
          mem_we = 1'b1;
          mem_waddr = rm_addr_q;
          mem_wdata = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q <= '0;
      phase_q <= PH_COLS;
      dcnt_q <= '0;
      m_valid_q <= 1'b0;
      rm_pend_q <= 1'b0;
      cw_q <= 12'd32;
      ch_q <= 12'd32;
      sw_q <= 12'd1024;
      sh_q <= 12'd768;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      phase_q <= phase_d;
      dcnt_q <= dcnt_d;
      m_valid_q <= m_valid_d;
      rm_pend_q <= rm_pend_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CELL_W:   cw_q <= cfg_data_i;
          CFG_CELL_H:   ch_q <= cfg_data_i;
          CFG_SCREEN_W: sw_q <= cfg_data_i;
          CFG_SCREEN_H: sh_q <= cfg_data_i;
          default: cw_q <= cw_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    tag_q <= tag_d;
    lft_q <= lft_d;
    tp_q <= tp_d;
    rgt_q <= rgt_d;
    bot_q <= bot_d;
    rows_up_q <= rows_up_d;
    cols_up_q <= cols_up_d;
    rows_outer_q <= rows_outer_d;
    x1_q <= x1_d;
    y1_q <= y1_d;
    x2_q <= x2_d;
    y2_q <= y2_d;
    w_q <= w_d;
    h_q <= h_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    cols_q <= cols_d;
    rows_q <= rows_d;
    nc_q <= nc_d;
    nr_q <= nr_d;
    cq0_q <= cq0_d;
    rq0_q <= rq0_d;
    mr_q <= mr_d;
    mc_q <= mc_d;
    corner_q <= corner_d;
    found_q <= found_d;
    i_q <= i_d;
    j_q <= j_d;
    r_q <= r_d;
    c_q <= c_d;
    ci_q <= ci_d;
    cj_q <= cj_d;
    px_q <= px_d;
    pw_q <= pw_d;
    py_q <= py_d;
    ph_q <= ph_d;
    ox1_q <= ox1_d;
    oy1_q <= oy1_d;
    rm_addr_q <= rm_addr_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  // no beat taken while the grid is cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready)
    else $error("beat accepted during clearing pass");

  // run checks never write the grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK_RD || state_q == ST_CHK_DAT || state_q == ST_NEXT ||
     state_q == ST_MAP) |-> !mem_we)
    else $error("grid written during run check");

  // claimed cells stay inside the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLAIM |-> (DIV_W'(ci_q) < nr_q && DIV_W'(cj_q) < nc_q))
    else $error("claim outside run");

  // divider step count bounded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= 5'(DIV_W + 1))
    else $error("divider step count out of range");

endmodule

`default_nettype wire

### verif/grid_rectangle_placer_core_tb.sv
// grid_rectangle_placer_core_tb: self-checking bench for the grid rectangle placer
// streams add and remove commands under several grid settings and flow-control phases,
// checks every result beat against a local grid model; depends on grp_pkg and the core
`timescale 1ns / 1ps

module grid_rectangle_placer_core_tb;
  import grp_pkg::*;

  localparam int ROWS_CAP = 32;
  localparam int COLS_CAP = 64;
  localparam int CELLS    = ROWS_CAP * COLS_CAP;
  localparam int STALL_LIMIT = 4000000;

  typedef struct {
    logic                op;
    logic [15:0]         owner;
    logic [COORD_W-1:0]  left, top, right, bottom;
    logic [1:0]          major, minor;
  } cmd_t;

  typedef struct {
    logic               placed;
    logic [COORD_W-1:0] left, top, right, bottom;
  } place_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [11:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  grid_rectangle_placer_core dut (.*);

  initial forever #2 clk_i = ~clk_i;

  // grid mirror and register copies
  logic        grid_used [CELLS];
  logic [15:0] grid_owner [CELLS];
  int unsigned cell_w_q = 32, cell_h_q = 32, scr_w_q = 1024, scr_h_q = 768;

  cmd_t   pend_q [$];
  place_t placement_q [$];
  int     idle_pct = 0, stall_pct = 0;
  logic   in_fire = 1'b0;
  int     errors = 0, sent = 0, checked = 0, quiet = 0, settings = 1;

  task automatic report(input string what);
    $display("mismatch %0s", what);
    errors++;
  endtask

  function automatic longint span_cells(input longint ext, input longint csize);
    if (ext <= 0) return 1;
    return (ext + csize - 1) / csize;
  endfunction

  function automatic bit run_is_free(input longint r, c, nr, nc);
    for (longint i = 0; i < nr; i++)
      for (longint j = 0; j < nc; j++)
        if (grid_used[(r + i) * COLS_CAP + (c + j)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic place_t place_predict(input cmd_t c);
    place_t p;
    longint x1, y1, x2, y2, cw, ch, sw, sh, rows, cols, nr, nc, mr, mc, w, h;
    longint r, cc;
    bit found, rows_up, cols_up;
    p = '{1'b0, '0, '0, '0, '0};
    r = 0; cc = 0; found = 1'b0;
    if (c.op == OP_REMOVE) begin
      for (int i = 0; i < CELLS; i++)
        if (grid_owner[i] == c.owner) begin
          grid_used[i] = 1'b0;
          grid_owner[i] = '0;
        end
      return p;
    end
    x1 = longint'($signed(c.left)); y1 = longint'($signed(c.top));
    x2 = longint'($signed(c.right)); y2 = longint'($signed(c.bottom));
    cw = cell_w_q ? cell_w_q : 1;
    ch = cell_h_q ? cell_h_q : 1;
    sw = scr_w_q; sh = scr_h_q;
    cols = sw / cw; if (cols > COLS_CAP) cols = COLS_CAP;
    rows = sh / ch; if (rows > ROWS_CAP) rows = ROWS_CAP;
    if (x1 < 0) begin x2 -= x1; x1 = 0; end
    if (y1 < 0) begin y2 -= y1; y1 = 0; end
    if (x2 >= sw) begin x1 -= x2 - (sw - 1); x2 = sw - 1; end
    if (y2 >= sh) begin y1 -= y2 - (sh - 1); y2 = sh - 1; end
    w = x2 - x1; h = y2 - y1;
    nc = span_cells(w, cw); nr = span_cells(h, ch);
    mr = rows - nr; mc = cols - nc;
    if (x1 >= 0 && y1 >= 0 && y1 / ch <= mr && x1 / cw <= mc) begin
      r = y1 / ch; cc = x1 / cw;
      found = run_is_free(r, cc, nr, nc);
    end
    if (!found && mr >= 0 && mc >= 0) begin
      if (c.major == DIR_LEFT || c.major == DIR_RIGHT) begin
        cols_up = (c.major == DIR_LEFT); rows_up = (c.minor == DIR_TOP);
        for (longint i = 0; i <= mr && !found; i++)
          for (longint j = 0; j <= mc && !found; j++) begin
            r = rows_up ? i : mr - i; cc = cols_up ? j : mc - j;
            found = run_is_free(r, cc, nr, nc);
          end
      end else begin
        rows_up = (c.major == DIR_TOP); cols_up = (c.minor == DIR_LEFT);
        for (longint j = 0; j <= mc && !found; j++)
          for (longint i = 0; i <= mr && !found; i++) begin
            r = rows_up ? i : mr - i; cc = cols_up ? j : mc - j;
            found = run_is_free(r, cc, nr, nc);
          end
      end
    end
    if (found) begin
      for (longint i = 0; i < nr; i++)
        for (longint j = 0; j < nc; j++) begin
          grid_used[(r + i) * COLS_CAP + (cc + j)] = 1'b1;
          grid_owner[(r + i) * COLS_CAP + (cc + j)] = c.owner;
        end
    end else begin
      r = 0; cc = 0;
    end
    x1 = cc * cw + (nc * cw - w) / 2;
    y1 = r * ch + (nr * ch - h) / 2;
    x2 = x1 + w;
    y2 = y1 + h;
    p.placed = found;
    p.left = x1[COORD_W-1:0];
    p.top = y1[COORD_W-1:0];
    p.right = x2[COORD_W-1:0];
    p.bottom = y2[COORD_W-1:0];
    return p;
  endfunction

  // driver: new beat at the falling edge once the previous one is taken
  always @(negedge clk_i) begin
    cmd_t c;
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    if (!s_axis_tvalid || in_fire) begin
      if (pend_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        c = pend_q.pop_front();
        s_axis_tdata <= {4'b0, c.minor, c.major, c.bottom, c.right, c.top, c.left, c.owner};
        s_axis_tuser <= c.op;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // input capture, prediction, result check and watchdog
  always @(posedge clk_i) begin
    cmd_t c;
    place_t e;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        c.op = s_axis_tuser[0];
        {c.minor, c.major, c.bottom, c.right, c.top, c.left, c.owner} = s_axis_tdata[75:0];
        placement_q.push_back(place_predict(c));
        sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (placement_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          e = placement_q.pop_front();
          checked++;
          if (m_axis_tuser[0] !== e.placed)
            report($sformatf("placed got %b exp %b", m_axis_tuser[0], e.placed));
          if (m_axis_tdata[13:0] !== e.left)
            report($sformatf("left got %h exp %h", m_axis_tdata[13:0], e.left));
          if (m_axis_tdata[27:14] !== e.top)
            report($sformatf("top got %h exp %h", m_axis_tdata[27:14], e.top));
          if (m_axis_tdata[41:28] !== e.right)
            report($sformatf("right got %h exp %h", m_axis_tdata[41:28], e.right));
          if (m_axis_tdata[55:42] !== e.bottom)
            report($sformatf("bottom got %h exp %h", m_axis_tdata[55:42], e.bottom));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("grid_rectangle_placer_core_tb failed");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[11:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CELL_W:   cell_w_q = 32'(val[11:0]);
      CFG_CELL_H:   cell_h_q = 32'(val[11:0]);
      CFG_SCREEN_W: scr_w_q = 32'(val[11:0]);
      default:      scr_h_q = 32'(val[11:0]);
    endcase
  endtask

  task automatic drain();
    wait (pend_q.size() == 0 && !s_axis_tvalid && placement_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic push_cmd(input logic op, input logic [15:0] owner, input int l, t, r, b,
                          input logic [1:0] maj, mnr);
    cmd_t c;
    c.op = op; c.owner = owner;
    c.left = l[13:0]; c.top = t[13:0]; c.right = r[13:0]; c.bottom = b[13:0];
    c.major = maj; c.minor = mnr;
    pend_q.push_back(c);
  endtask

  task automatic push_random(input int n);
    int l, t, wd, ht;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        push_cmd(OP_REMOVE, ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                 16'($urandom_range(0, 6)), $urandom, $urandom, $urandom, $urandom,
                 2'($urandom), 2'($urandom));
      end else if ($urandom_range(0, 99) < 20) begin
        push_cmd(OP_ADD, 16'($urandom), $urandom, $urandom, $urandom, $urandom,
                 2'($urandom), 2'($urandom));
      end else begin
        wd = $urandom_range(0, 3 * cell_w_q);
        ht = $urandom_range(0, 3 * cell_h_q);
        l = int'($urandom_range(0, scr_w_q)) - int'($urandom_range(0, 40));
        t = int'($urandom_range(0, scr_h_q)) - int'($urandom_range(0, 40));
        push_cmd(OP_ADD, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                 16'($urandom_range(1, 6)), l, t, l + wd, t + ht,
                 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      grid_used[i] = 1'b0;
      grid_owner[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed commands on the reset grid
    push_cmd(OP_ADD, 16'd1, 10, 10, 50, 40, DIR_LEFT, DIR_TOP);
    push_cmd(OP_ADD, 16'd2, 10, 10, 50, 40, DIR_LEFT, DIR_TOP);
    push_cmd(OP_ADD, 16'd3, 10, 10, 50, 40, DIR_RIGHT, DIR_BOTTOM);
    push_cmd(OP_ADD, 16'd4, 10, 10, 50, 40, DIR_TOP, DIR_LEFT);
    push_cmd(OP_ADD, 16'd5, 10, 10, 50, 40, DIR_BOTTOM, DIR_RIGHT);
    push_cmd(OP_ADD, 16'd6, -100, -30, 20, 5, DIR_RIGHT, DIR_TOP);
    push_cmd(OP_ADD, 16'd7, 1000, 700, 1100, 800, DIR_BOTTOM, DIR_LEFT);
    push_cmd(OP_ADD, 16'd8, 300, 300, 200, 250, DIR_TOP, DIR_RIGHT);
    push_cmd(OP_ADD, 16'hffff, -8192, -8192, 8191, 8191, DIR_LEFT, DIR_BOTTOM);
    push_cmd(OP_ADD, 16'hffff, 8191, 8191, -8192, -8192, DIR_RIGHT, DIR_LEFT);
    push_cmd(OP_ADD, 16'h0000, 500, 500, 500, 500, DIR_LEFT, DIR_TOP);
    push_cmd(OP_ADD, 16'h0000, 0, 0, 1023, 767, DIR_TOP, DIR_TOP);
    push_cmd(OP_REMOVE, 16'h0000, 0, 0, 0, 0, DIR_LEFT, DIR_LEFT);
    push_cmd(OP_REMOVE, 16'd2, 0, 0, 0, 0, DIR_LEFT, DIR_LEFT);
    push_cmd(OP_ADD, 16'd9, 0, 0, 1023, 767, DIR_TOP, DIR_TOP);
    push_cmd(OP_REMOVE, 16'hffff, 0, 0, 0, 0, DIR_LEFT, DIR_LEFT);
    for (int k = 1; k <= 9; k++) push_cmd(OP_REMOVE, 16'(k), 0, 0, 0, 0, DIR_LEFT, DIR_LEFT);
    push_random(120);
    drain();

    for (int ph = 1; ph < 5; ph++) begin
      case (ph)
        1: begin idle_pct = 74; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 74; end
        3: begin idle_pct = 34; stall_pct = 34; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      case (ph)
        1: begin
          cfg_write(CFG_CELL_W, 100); cfg_write(CFG_CELL_H, 75);
          cfg_write(CFG_SCREEN_W, 400); cfg_write(CFG_SCREEN_H, 300);
        end
        2: begin
          cfg_write(CFG_CELL_W, 1); cfg_write(CFG_CELL_H, 1);
          cfg_write(CFG_SCREEN_W, 4095); cfg_write(CFG_SCREEN_H, 4095);
        end
        3: begin
          cfg_write(CFG_CELL_W, 4095); cfg_write(CFG_CELL_H, 4095);
          cfg_write(CFG_SCREEN_W, 4095); cfg_write(CFG_SCREEN_H, 4095);
        end
        default: begin
          cfg_write(CFG_CELL_W, 64); cfg_write(CFG_CELL_H, 48);
          cfg_write(CFG_SCREEN_W, 1); cfg_write(CFG_SCREEN_H, 1);
          push_random(15);
          drain();
          cfg_write(CFG_SCREEN_W, 640); cfg_write(CFG_SCREEN_H, 480);
        end
      endcase
      settings++;
      push_random(ph == 4 ? 95 : 110);
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("%0d commands sent, %0d result beats checked, %0d errors", sent, checked, errors);
    $display("covered %0d grid settings under free, idle-sender, stalled and mixed flow",
             settings);
    if (errors == 0 && placement_q.size() == 0) begin
      $display("grid_rectangle_placer_core_tb passed");
    end else begin
      $display("grid_rectangle_placer_core_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/grp_pkg.sv
rtl/core/grid_rectangle_placer_core.sv
verif/grid_rectangle_placer_core_tb.sv
